// File: hdl/red_pkg.sv
// Package: widths, the square-root cell payload type and pipeline latency.
`timescale 1ns / 1ps

package red_pkg;

    localparam int COORD_BITS = 8;
    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int DIST_BITS  = COORD_BITS + 1;

    // One cell per root bit; each cell consumes two radicand bits.
    localparam int NUM_CELLS  = DIST_BITS;
    localparam int RAD_BITS   = 2 * NUM_CELLS;
    localparam int REM_BITS   = DIST_BITS + 2;

    // Registers from the input transfer to the result strobe:
    // difference, square, sum, one per cell, rounding.
    localparam int LATENCY    = NUM_CELLS + 4;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [SQ_BITS-1:0]    sq_t;
    typedef logic [DIST_BITS-1:0]  dist_t;

    typedef struct packed {
        logic [RAD_BITS-1:0] rad;   // radicand bits not yet consumed, top first
        logic [REM_BITS-1:0] rem;   // partial remainder
        dist_t               root;  // partial root
        sq_t                 sq;    // squared distance, carried to the output
    } red_data_t;

endpackage

// File: hdl/red_front.sv
// Front end: absolute differences, squares and their sum, three register stages.
`timescale 1ns / 1ps

module red_front
    import red_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  coord_t    first_x,
    input  coord_t    first_y,
    input  coord_t    second_x,
    input  coord_t    second_y,
    output logic      out_valid,
    output red_data_t out_data
);

    logic                    diff_valid_reg;
    coord_t                  dx_reg, dx_next;
    coord_t                  dy_reg, dy_next;
    logic                    sqr_valid_reg;
    logic [2*COORD_BITS-1:0] sqx_reg, sqx_next;
    logic [2*COORD_BITS-1:0] sqy_reg, sqy_next;
    logic                    sum_valid_reg;
    sq_t                     sum_reg, sum_next;

    always_comb
    begin
        dx_next  = (first_x >= second_x) ? (first_x - second_x) : (second_x - first_x);
        dy_next  = (first_y >= second_y) ? (first_y - second_y) : (second_y - first_y);
        sqx_next = {{COORD_BITS{1'b0}}, dx_reg} * {{COORD_BITS{1'b0}}, dx_reg};
        sqy_next = {{COORD_BITS{1'b0}}, dy_reg} * {{COORD_BITS{1'b0}}, dy_reg};
        sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            sqr_valid_reg  <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            diff_valid_reg <= in_valid;
            sqr_valid_reg  <= diff_valid_reg;
            sum_valid_reg  <= sqr_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        sum_reg <= sum_next;
    end

    assign out_valid     = sum_valid_reg;
    assign out_data.rad  = {1'b0, sum_reg};
    assign out_data.rem  = '0;
    assign out_data.root = '0;
    assign out_data.sq   = sum_reg;

endmodule

// File: hdl/red_cell.sv
// One square-root cell: resolves one root bit from two radicand bits.
`timescale 1ns / 1ps

module red_cell
    import red_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  red_data_t in_data,
    output logic      out_valid,
    output red_data_t out_data
);

    logic                valid_reg;
    red_data_t           data_reg, data_next;
    logic [REM_BITS-1:0] work;
    logic [REM_BITS-1:0] trial;
    logic                fits;

    always_comb
    begin
        // Shift two new radicand bits into the remainder, try root*4+1.
        work  = {in_data.rem[REM_BITS-3:0], in_data.rad[RAD_BITS-1 -: 2]};
        trial = {in_data.root, 2'b01};
        fits  = (work >= trial);

        data_next.rad  = {in_data.rad[RAD_BITS-3:0], 2'b00};
        data_next.rem  = fits ? (work - trial) : work;
        data_next.root = {in_data.root[DIST_BITS-2:0], fits};
        data_next.sq   = in_data.sq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/rounded_euclidean_distance.sv
// Top level: rounded Euclidean distance between two points, fully pipelined.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+--------------------------------------------
//   command  | start / busy         | first_x, first_y, second_x, second_y
//   result   | done (one-cycle)     | squared_distance, distance
//
// A transfer happens on each edge with start high and busy low; busy is
// always low, so a new pair may enter every cycle. After its transfer, each
// result passes through three front stages, one register per root bit in the
// cell chain, and a rounding register. Reset clears only the valid bits. The
// receiver cannot stall, so nothing in the pipeline ever holds.
`timescale 1ns / 1ps

module rounded_euclidean_distance
    import red_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    input  coord_t first_x,
    input  coord_t first_y,
    input  coord_t second_x,
    input  coord_t second_y,
    output logic   done,
    output sq_t    squared_distance,
    output dist_t  distance
);

    // Chain links: link 0 is the front end output, link k the output of cell k-1.
    logic      link_valid [NUM_CELLS+1];
    red_data_t link_data  [NUM_CELLS+1];

    logic      done_reg;
    sq_t       sq_reg;
    dist_t     dist_reg, dist_next;
    red_data_t last;
    logic      round_up;

    // Fixed-latency pipeline: never refuse a command.
    assign busy = 1'b0;

    red_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .first_x   (first_x),
        .first_y   (first_y),
        .second_x  (second_x),
        .second_y  (second_y),
        .out_valid (link_valid[0]),
        .out_data  (link_data[0])
    );

    // Restoring square-root chain: cell k resolves root bit NUM_CELLS-1-k.
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        red_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    // Rounding: with floor root r and remainder d - r*r, the nearest integer
    // is r+1 exactly when the remainder exceeds r (halfway cannot occur).
    always_comb
    begin
        last      = link_data[NUM_CELLS];
        round_up  = (last.rem > {2'b00, last.root});
        dist_next = last.root + {{(DIST_BITS-1){1'b0}}, round_up};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= link_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= last.sq;
        dist_reg <= dist_next;
    end

    assign done             = done_reg;
    assign squared_distance = sq_reg;
    assign distance         = dist_reg;

`ifndef SYNTHESIS
    localparam int CHK_BITS = 2 * DIST_BITS + 2;

    logic [CHK_BITS-1:0] chk_i;
    logic [CHK_BITS-1:0] chk_ii;
    logic [CHK_BITS-1:0] chk_d;

    assign chk_i  = {{(CHK_BITS-DIST_BITS){1'b0}}, distance};
    assign chk_ii = chk_i * chk_i;
    assign chk_d  = {{(CHK_BITS-SQ_BITS){1'b0}}, squared_distance};

    // Every transfer yields its result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result strobe missing after command transfer");

    // No result without a transfer the fixed latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##LATENCY !done)
        else $error("result strobe without a command transfer");

    // The rounded root lies within half a step: |d - i*i| <= i.
    a_nearest: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (chk_d <= chk_ii + chk_i) && (chk_d + chk_i >= chk_ii))
        else $error("distance is not the nearest integer root");
`endif

endmodule
